/* rtl/mts_pkg.sv */
// Shared types, constants and helpers of the mipmap texture sampler.
`default_nettype none
package mts_pkg;

    localparam int MAX_LEVELS      = 9;
    localparam int STORE_DEPTH     = 131072;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = COORD_FRAC_BITS + 1;
    localparam int SIZE_W          = 9;
    localparam int POS_W           = 8;
    localparam int LVL_W           = $clog2(MAX_LEVELS + 1);
    localparam int LIDX_W          = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int WT_W            = 9;
    localparam int WXY_W           = 2 * WT_W - 1;
    localparam int TW_W            = WXY_W + WT_W - 1;
    localparam int RGB_W           = 24;
    localparam int TAPS            = 8;
    localparam int LOD_LAT         = 13;
    localparam int ADDR_LAT        = 3;
    localparam int IN_ADDR_W       = 17;

    localparam logic [1:0] CFG_BASE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_BASE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd2;

    localparam logic [1:0] LMODE_ZERO    = 2'd0;
    localparam logic [1:0] LMODE_NEAREST = 2'd1;
    localparam logic [1:0] LMODE_LINEAR  = 2'd2;
    localparam logic [1:0] LMODE_BLACK   = 2'd3;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic [LIDX_W-1:0] lv_a;
        logic [LIDX_W-1:0] lv_b;
        logic [WT_W-1:0]   lw_a;
        logic [WT_W-1:0]   lw_b;
    } lvl_sel_t;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               bilin;
        logic [1:0]         mode;
        logic [ADDR_W-1:0]  addr;
        logic [RGB_W-1:0]   rgb;
    } side_t;

    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
        return (s == '0) ? SIZE_W'(1) : s;
    endfunction

    function automatic logic [SIZE_W-1:0] dim_at(logic [SIZE_W-1:0] s,
                                                 logic [LIDX_W-1:0] lvl);
        logic [SIZE_W-1:0] d;
        d = eff_size(s) >> lvl;
        return (d == '0) ? SIZE_W'(1) : d;
    endfunction

endpackage
`default_nettype wire

/* rtl/mts_ram.sv */
// Texel store copy: one write port, one registered read port.
`default_nettype none
module mts_ram
    import mts_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [RGB_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [RGB_W-1:0]  rdata
);

    logic [RGB_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/mts_lod.sv */
// Level of detail pipeline: footprint, squared length, log2, level select.
`default_nettype none
module mts_lod
    import mts_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [COORD_W-1:0] cu,
    input  logic [COORD_W-1:0] cv,
    input  logic [COORD_W-1:0] ru,
    input  logic [COORD_W-1:0] rv,
    input  logic [COORD_W-1:0] bu,
    input  logic [COORD_W-1:0] bv,
    input  logic [1:0]         level_mode,
    input  logic [SIZE_W-1:0]  width_eff,
    input  logic [SIZE_W-1:0]  height_eff,
    input  logic [LVL_W-1:0]   levels_eff,
    output lvl_sel_t           sel
);

    localparam int MAG_SH = COORD_FRAC_BITS - 8;
    localparam int MAG_W  = COORD_W;
    localparam int SQ_W   = 2 * MAG_W + 1;
    localparam int MSB_W  = $clog2(SQ_W);
    localparam int M_W    = 31;
    localparam int NITER  = 9;
    localparam int LQ_W   = MSB_W + NITER;
    localparam int NMODE  = LOD_LAT - 1;
    localparam logic [LQ_W-1:0] LG_OFF = LQ_W'(16 << NITER);

    function automatic logic [MAG_W-1:0] mag(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                             logic [SIZE_W-1:0] s);
        logic [COORD_W-1:0]        d;
        logic [COORD_W+SIZE_W-1:0] p;
        d = (a > b) ? a - b : b - a;
        p = d * s;
        return p[MAG_SH +: MAG_W];
    endfunction

    logic [MAG_W-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic [SQ_W-1:0]  sq1_reg, sq2_reg;
    logic [M_W-1:0]   m_reg    [NITER+1];
    logic [NITER-1:0] frac_reg [NITER+1];
    logic [MSB_W-1:0] msb_reg  [NITER+1];
    logic             zero_reg [NITER+1];
    logic [1:0]       mode_reg [NMODE];
    lvl_sel_t         sel_reg;

    logic [LQ_W-1:0]   lg, lq_raw, lq_max, lq, ln;
    logic [LIDX_W-1:0] top_lvl, lo;
    logic [7:0]        f;
    lvl_sel_t          sel_next;

    logic [SQ_W-1:0]  raw;
    logic [SQ_W-1:0]  norm;
    logic [MSB_W-1:0] msb;

    always_comb
    begin
        raw = (sq1_reg > sq2_reg) ? sq1_reg : sq2_reg;
        msb = '0;
        for (int b = 0; b < SQ_W; b++)
        begin
            if (raw[b])
            begin
                msb = MSB_W'(b);
            end
        end
        if (msb >= MSB_W'(M_W - 1))
        begin
            norm = raw >> (msb - MSB_W'(M_W - 1));
        end
        else
        begin
            norm = raw << (MSB_W'(M_W - 1) - msb);
        end
    end

    // one squaring per stage: bit out when the square reaches 2.0
    logic [M_W:0]   sq_q   [NITER];
    logic [M_W-1:0] m_next [NITER];
    logic           f_bit  [NITER];

    always_comb
    begin
        for (int k = 0; k < NITER; k++)
        begin
            sq_q[k]  = (M_W + 1)'((2 * M_W)'(m_reg[k]) * (2 * M_W)'(m_reg[k]) >> (M_W - 1));
            f_bit[k] = sq_q[k][M_W];
            m_next[k] = f_bit[k] ? sq_q[k][M_W:1] : sq_q[k][M_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg <= mag(ru, cu, width_eff);
            d1y_reg <= mag(rv, cv, height_eff);
            d2x_reg <= mag(bu, cu, width_eff);
            d2y_reg <= mag(bv, cv, height_eff);
            sq1_reg <= SQ_W'(d1x_reg * d1x_reg) + SQ_W'(d1y_reg * d1y_reg);
            sq2_reg <= SQ_W'(d2x_reg * d2x_reg) + SQ_W'(d2y_reg * d2y_reg);
            m_reg[0]    <= norm[M_W-1:0];
            msb_reg[0]  <= msb;
            zero_reg[0] <= (raw == '0);
            frac_reg[0] <= '0;
            for (int k = 1; k <= NITER; k++)
            begin
                m_reg[k]    <= m_next[k-1];
                msb_reg[k]  <= msb_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                frac_reg[k] <= {frac_reg[k-1][NITER-2:0], f_bit[k-1]};
            end
            mode_reg[0] <= level_mode;
            for (int k = 1; k < NMODE; k++)
            begin
                mode_reg[k] <= mode_reg[k-1];
            end
            sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        lg = {msb_reg[NITER], frac_reg[NITER]};
        if (!zero_reg[NITER] && lg > LG_OFF)
        begin
            lq_raw = (lg - LG_OFF) >> 1;
        end
        else
        begin
            lq_raw = '0;
        end
        top_lvl = LIDX_W'(levels_eff - LVL_W'(1));
        lq_max  = LQ_W'(top_lvl) << 8;
        lq      = (lq_raw > lq_max) ? lq_max : lq_raw;
        ln      = (lq + LQ_W'(128)) >> 8;
        lo      = LIDX_W'(lq >> 8);
        f       = '0;
        sel_next.lv_a = '0;
        sel_next.lv_b = '0;
        unique case (mode_reg[NMODE-1])
            LMODE_ZERO:
            begin
                sel_next.lv_a = '0;
            end
            LMODE_NEAREST:
            begin
                sel_next.lv_a = (ln > LQ_W'(top_lvl)) ? top_lvl : LIDX_W'(ln);
            end
            LMODE_LINEAR:
            begin
                sel_next.lv_a = lo;
                sel_next.lv_b = (LVL_W'(lo) + LVL_W'(1) < levels_eff) ?
                                LIDX_W'(lo + LIDX_W'(1)) : top_lvl;
                f = lq[7:0];
            end
            default:
            begin
                sel_next.lv_a = '0;
            end
        endcase
        sel_next.lw_a = WT_W'(256) - WT_W'(f);
        sel_next.lw_b = WT_W'(f);
    end

    assign sel = sel_reg;

endmodule
`default_nettype wire

/* rtl/mts_addr.sv */
// Texel address and weight pipeline for the two selected levels.
`default_nettype none
module mts_addr
    import mts_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  lvl_sel_t           sel,
    input  logic [COORD_W-1:0] u,
    input  logic [COORD_W-1:0] v,
    input  logic               bilin,
    input  logic [SIZE_W-1:0]  base_width,
    input  logic [SIZE_W-1:0]  base_height,
    output logic [ADDR_W-1:0]  tap_addr [TAPS],
    output logic [WXY_W-1:0]   tap_wxy  [TAPS],
    output logic [WT_W-1:0]    lw       [2]
);

    localparam int TX_W = COORD_W + POS_W;
    localparam int PR_W = 2 * SIZE_W - 1;
    localparam logic [TX_W-1:0] HALF = TX_W'(1) << (COORD_FRAC_BITS - 1);

    logic [PR_W-1:0] prod_reg [MAX_LEVELS];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            prod_reg[k] <= PR_W'(dim_at(base_width, LIDX_W'(k)) *
                                 dim_at(base_height, LIDX_W'(k)));
        end
    end

    // stage one
    logic [TX_W-1:0]   tx_reg [2], ty_reg [2];
    logic [SIZE_W-1:0] w1_reg [2], h1_reg [2];
    logic [ADDR_W-1:0] b1_reg [2];
    logic [WT_W-1:0]   l1_reg [2];
    logic              bil1_reg;

    logic [LIDX_W-1:0] lv    [2];
    logic [SIZE_W-1:0] wd    [2], hd [2];
    logic [ADDR_W-1:0] lbase [2];

    always_comb
    begin
        lv[0] = sel.lv_a;
        lv[1] = sel.lv_b;
        for (int k = 0; k < 2; k++)
        begin
            wd[k]    = dim_at(base_width, lv[k]);
            hd[k]    = dim_at(base_height, lv[k]);
            lbase[k] = '0;
            for (int j = 0; j < MAX_LEVELS; j++)
            begin
                if (LIDX_W'(j) < lv[k])
                begin
                    lbase[k] = lbase[k] + ADDR_W'(prod_reg[j]);
                end
            end
        end
    end

    // stage two
    logic [POS_W-1:0]  x_reg [2][2], y_reg [2][2];
    logic [WT_W-1:0]   wx_reg [2][2], wy_reg [2][2];
    logic [SIZE_W-1:0] w2_reg [2];
    logic [ADDR_W-1:0] b2_reg [2];
    logic [WT_W-1:0]   l2_reg [2];

    logic [POS_W-1:0]  xs [2][2], ys [2][2];
    logic [WT_W-1:0]   wxs [2][2], wys [2][2];
    logic [TX_W-1:0]   rx, ry;
    logic [POS_W-1:0]  s, t;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rx = (tx_reg[k] + HALF) >> COORD_FRAC_BITS;
            ry = (ty_reg[k] + HALF) >> COORD_FRAC_BITS;
            s  = tx_reg[k][COORD_FRAC_BITS-1 -: POS_W];
            t  = ty_reg[k][COORD_FRAC_BITS-1 -: POS_W];
            if (!bil1_reg)
            begin
                xs[k][0] = POS_W'(rx);
                xs[k][1] = POS_W'(rx);
                ys[k][0] = POS_W'(ry);
                ys[k][1] = POS_W'(ry);
                wxs[k][0] = WT_W'(256);
                wxs[k][1] = '0;
                wys[k][0] = WT_W'(256);
                wys[k][1] = '0;
            end
            else
            begin
                xs[k][0] = tx_reg[k][COORD_FRAC_BITS +: POS_W];
                ys[k][0] = ty_reg[k][COORD_FRAC_BITS +: POS_W];
                xs[k][1] = (SIZE_W'(xs[k][0]) + SIZE_W'(1) < w1_reg[k]) ?
                           xs[k][0] + POS_W'(1) : POS_W'(w1_reg[k] - SIZE_W'(1));
                ys[k][1] = (SIZE_W'(ys[k][0]) + SIZE_W'(1) < h1_reg[k]) ?
                           ys[k][0] + POS_W'(1) : POS_W'(h1_reg[k] - SIZE_W'(1));
                wxs[k][0] = WT_W'(256) - WT_W'(s);
                wxs[k][1] = WT_W'(s);
                wys[k][0] = WT_W'(256) - WT_W'(t);
                wys[k][1] = WT_W'(t);
            end
        end
    end

    // stage three
    logic [ADDR_W-1:0] addr_reg [TAPS];
    logic [WXY_W-1:0]  wxy_reg  [TAPS];
    logic [WT_W-1:0]   l3_reg   [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bil1_reg <= bilin;
            for (int k = 0; k < 2; k++)
            begin
                tx_reg[k] <= TX_W'(u * POS_W'(wd[k] - SIZE_W'(1)));
                ty_reg[k] <= TX_W'(v * POS_W'(hd[k] - SIZE_W'(1)));
                w1_reg[k] <= wd[k];
                h1_reg[k] <= hd[k];
                b1_reg[k] <= lbase[k];
                w2_reg[k] <= w1_reg[k];
                b2_reg[k] <= b1_reg[k];
                l2_reg[k] <= l1_reg[k];
                l3_reg[k] <= l2_reg[k];
                for (int i = 0; i < 2; i++)
                begin
                    x_reg[k][i]  <= xs[k][i];
                    y_reg[k][i]  <= ys[k][i];
                    wx_reg[k][i] <= wxs[k][i];
                    wy_reg[k][i] <= wys[k][i];
                end
                for (int j = 0; j < 2; j++)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        addr_reg[k*4 + j*2 + i] <= b2_reg[k] +
                            ADDR_W'(y_reg[k][j] * w2_reg[k]) + ADDR_W'(x_reg[k][i]);
                        wxy_reg[k*4 + j*2 + i] <= WXY_W'(wx_reg[k][i] * wy_reg[k][j]);
                    end
                end
            end
            l1_reg[0] <= sel.lw_a;
            l1_reg[1] <= sel.lw_b;
        end
    end

    assign tap_addr = addr_reg;
    assign tap_wxy  = wxy_reg;
    assign lw       = l3_reg;

endmodule
`default_nettype wire

/* rtl/mts_filter.sv */
// Weighted sum of the eight fetched texels per color channel.
`default_nettype none
module mts_filter
    import mts_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [RGB_W-1:0] texel [TAPS],
    input  logic [TW_W-1:0]  wt    [TAPS],
    output logic [7:0]       chan  [3]
);

    localparam int PR_W  = 8 + TW_W;
    localparam int ACC_W = PR_W + $clog2(TAPS);
    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << 23;

    logic [PR_W-1:0] prod_reg [3][TAPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int n = 0; n < TAPS; n++)
                begin
                    prod_reg[c][n] <= PR_W'(texel[n][16 - 8*c +: 8] * wt[n]);
                end
            end
        end
    end

    logic [ACC_W-1:0] acc [3];
    logic [ACC_W-1:0] ch  [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = RND;
            for (int n = 0; n < TAPS; n++)
            begin
                acc[c] = acc[c] + ACC_W'(prod_reg[c][n]);
            end
            ch[c]   = acc[c] >> 24;
            chan[c] = (ch[c] > ACC_W'(255)) ? 8'd255 : ch[c][7:0];
        end
    end

endmodule
`default_nettype wire

/* rtl/mipmap_texture_sampler.sv */
// Top level of the mipmapped trilinear texture sampler.
// One beat in per cycle while in_stall is low, and one result out per sample
// beat. A sample passes through the 13-stage level of detail pipeline (nine
// of them one log2 squaring step each), three address stages, the registered
// store read, the filter product register and the result register. Texel
// writes go through the same pipeline and land in the store in order with
// samples, so a sample sees every write accepted before it. The store is
// eight replicated copies, one per bilinear tap of the two levels. Unwritten
// texels read as whatever the store holds. No reset sweep of the store.
`default_nettype none
module mipmap_texture_sampler
    import mts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [COORD_W-1:0]   coord_u,
    input  logic [COORD_W-1:0]   coord_v,
    input  logic [COORD_W-1:0]   right_u,
    input  logic [COORD_W-1:0]   right_v,
    input  logic [COORD_W-1:0]   below_u,
    input  logic [COORD_W-1:0]   below_v,
    input  logic [1:0]           level_mode,
    input  logic                 pixel_mode,
    input  logic [IN_ADDR_W-1:0] texel_addr,
    input  logic [RGB_W-1:0]     texel_rgb,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam int SIDE_N  = LOD_LAT + ADDR_LAT + 3;
    localparam int ST_LOD  = LOD_LAT;
    localparam int ST_ADDR = LOD_LAT + ADDR_LAT;
    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << COORD_FRAC_BITS;

    function automatic logic [COORD_W-1:0] sat(logic [COORD_W-1:0] c);
        return (c > ONE) ? ONE : c;
    endfunction

    // configuration
    logic [SIZE_W-1:0] base_width_reg, base_height_reg;
    logic [3:0]        level_count_reg;
    logic [LVL_W-1:0]  levels_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg  <= SIZE_W'(256);
            base_height_reg <= SIZE_W'(256);
            level_count_reg <= 4'd9;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE_WIDTH:  base_width_reg  <= cfg_data;
                CFG_BASE_HEIGHT: base_height_reg <= cfg_data;
                CFG_LEVEL_COUNT: level_count_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (level_count_reg == 4'd0)
        begin
            levels_eff = LVL_W'(1);
        end
        else if (32'(level_count_reg) > MAX_LEVELS)
        begin
            levels_eff = LVL_W'(MAX_LEVELS);
        end
        else
        begin
            levels_eff = LVL_W'(level_count_reg);
        end
    end

    // pipeline control: every stage moves together
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    side_t              side_reg       [SIDE_N];
    logic [SIDE_N-1:0]  side_valid_reg;
    logic [COORD_W-1:0] ru_reg, rv_reg, bu_reg, bv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= '0;
        end
        else if (advance)
        begin
            side_valid_reg <= {side_valid_reg[SIDE_N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0].func  <= func;
            side_reg[0].u     <= sat(coord_u);
            side_reg[0].v     <= sat(coord_v);
            side_reg[0].bilin <= pixel_mode;
            side_reg[0].mode  <= level_mode;
            side_reg[0].addr  <= ADDR_W'(texel_addr);
            side_reg[0].rgb   <= texel_rgb;
            ru_reg <= sat(right_u);
            rv_reg <= sat(right_v);
            bu_reg <= sat(below_u);
            bv_reg <= sat(below_v);
            for (int s = 1; s < SIDE_N; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    lvl_sel_t lod_sel;

    mts_lod u_lod (
        .clk        (clk),
        .en         (advance),
        .cu         (side_reg[0].u),
        .cv         (side_reg[0].v),
        .ru         (ru_reg),
        .rv         (rv_reg),
        .bu         (bu_reg),
        .bv         (bv_reg),
        .level_mode (side_reg[0].mode),
        .width_eff  (eff_size(base_width_reg)),
        .height_eff (eff_size(base_height_reg)),
        .levels_eff (levels_eff),
        .sel        (lod_sel)
    );

    logic [ADDR_W-1:0] tap_addr [TAPS];
    logic [WXY_W-1:0]  tap_wxy  [TAPS];
    logic [WT_W-1:0]   tap_lw   [2];

    mts_addr u_addr (
        .clk         (clk),
        .en          (advance),
        .sel         (lod_sel),
        .u           (side_reg[ST_LOD].u),
        .v           (side_reg[ST_LOD].v),
        .bilin       (side_reg[ST_LOD].bilin),
        .base_width  (base_width_reg),
        .base_height (base_height_reg),
        .tap_addr    (tap_addr),
        .tap_wxy     (tap_wxy),
        .lw          (tap_lw)
    );

    // store: texel writes land at the same stage as sample reads
    logic             st_we;
    logic [RGB_W-1:0] texel [TAPS];

    assign st_we = advance && side_valid_reg[ST_ADDR] &&
                   (side_reg[ST_ADDR].func == FUNC_WRITE);

    for (genvar n = 0; n < TAPS; n++)
    begin : g_bank
        mts_ram u_ram (
            .clk   (clk),
            .we    (st_we),
            .waddr (side_reg[ST_ADDR].addr),
            .wdata (side_reg[ST_ADDR].rgb),
            .re    (advance),
            .raddr (tap_addr[n]),
            .rdata (texel[n])
        );
    end

    logic [TW_W-1:0] wt_reg [TAPS];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int n = 0; n < TAPS; n++)
            begin
                wt_reg[n] <= TW_W'(tap_wxy[n] * tap_lw[n / 4]);
            end
        end
    end

    logic [7:0] chan [3];

    mts_filter u_filter (
        .clk   (clk),
        .en    (advance),
        .texel (texel),
        .wt    (wt_reg),
        .chan  (chan)
    );

    // result register
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       black;

    assign black = (side_reg[SIDE_N-1].mode == LMODE_BLACK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= side_valid_reg[SIDE_N-1] &&
                             (side_reg[SIDE_N-1].func == FUNC_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= black ? 8'd0 : chan[0];
            green_reg <= black ? 8'd0 : chan[1];
            blue_reg  <= black ? 8'd0 : chan[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef SYNTHESIS
    localparam int WS_W = WXY_W + 2;

    a_out_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(side_valid_reg[SIDE_N-1] && (side_reg[SIDE_N-1].func == FUNC_SAMPLE)))
        else $error("result beat without a sample at the last stage");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        side_valid_reg[ST_LOD] && (side_reg[ST_LOD].func == FUNC_SAMPLE) |->
            (LVL_W'(lod_sel.lv_a) < levels_eff) && (LVL_W'(lod_sel.lv_b) < levels_eff))
        else $error("selected level beyond level count");

    a_weights_unit: assert property (@(posedge clk) disable iff (!rst_n)
        side_valid_reg[ST_ADDR] && (side_reg[ST_ADDR].func == FUNC_SAMPLE) |->
            (WS_W'(tap_wxy[0]) + WS_W'(tap_wxy[1]) + WS_W'(tap_wxy[2]) +
             WS_W'(tap_wxy[3])) == (WS_W'(1) << 16))
        else $error("bilinear weights do not sum to one");
`endif

endmodule
`default_nettype wire
